>>> src/led_chaser_pattern_sequencer_unit_macros.svh
// Assertion macros used by the LED chaser pattern sequencer frame core.
`ifndef LED_CHASER_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define LED_CHASER_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LCPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LCPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lcps_pkg.sv
// Types, constants and mask functions of the LED chaser pattern sequencer.
package lcps_pkg;

	localparam int LED_COUNT        = 32;
	localparam int BLINK_HOLD_TICKS = 2;
	localparam int HALF_COUNT       = LED_COUNT / 2;
	localparam int OUT_W            = 32;
	localparam int CNT_W            = $clog2(LED_COUNT);
	localparam int HOLD_W           = $clog2(BLINK_HOLD_TICKS + 1);

	localparam logic       REQ_TICK = 1'b0;
	localparam logic       REQ_KEY  = 1'b1;
	localparam logic [3:0] KEY_LAST = 4'd6;

	typedef enum logic [2:0] {
		MODE_BLINK,
		MODE_FILL_LOW,
		MODE_FILL_HIGH,
		MODE_FILL_ENDS,
		MODE_FILL_MID,
		MODE_DOT_LOW,
		MODE_DOT_HIGH
	} mode_t;

	typedef logic [LED_COUNT-1:0] pattern_t;

	typedef struct packed {
		logic       req_type;
		logic [3:0] key_code;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] led_pattern;
		logic [2:0]       current_mode;
	} result_t;

	// Lowest k LEDs lit.
	function automatic pattern_t low_bits(input logic [CNT_W:0] k);
		pattern_t r;
		for (int i = 0; i < LED_COUNT; i++) begin
			r[i] = (i < int'(k));
		end
		return r;
	endfunction

	// Highest k LEDs lit.
	function automatic pattern_t high_bits(input logic [CNT_W:0] k);
		pattern_t r;
		for (int i = 0; i < LED_COUNT; i++) begin
			r[i] = (i >= LED_COUNT - int'(k));
		end
		return r;
	endfunction

	// 2k LEDs lit around the middle, starting at HALF_COUNT - k.
	function automatic pattern_t mid_bits(input logic [CNT_W:0] k);
		pattern_t r;
		for (int i = 0; i < LED_COUNT; i++) begin
			r[i] = (i >= HALF_COUNT - int'(k)) && (i < HALF_COUNT + int'(k));
		end
		return r;
	endfunction

	// A single LED lit.
	function automatic pattern_t bit_at(input logic [CNT_W-1:0] p);
		pattern_t r;
		for (int i = 0; i < LED_COUNT; i++) begin
			r[i] = (i == int'(p));
		end
		return r;
	endfunction

	// Low OUT_W LEDs of the bank, zero filled when the bank is narrower.
	function automatic logic [OUT_W-1:0] to_out(input pattern_t p);
		logic [OUT_W-1:0] r;
		r = '0;
		for (int i = 0; i < OUT_W; i++) begin
			if (i < LED_COUNT) begin
				r[i] = p[i];
			end
		end
		return r;
	endfunction

endpackage

>>> src/lcps_in_stage.sv
// Input register stage: holds one word until the frame core can consume it.
module lcps_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                req_type,
	input  logic [3:0]          key_code,
	input  logic                out_free,
	output logic                fire,
	output lcps_pkg::item_t     item_s1
);
	import lcps_pkg::*;

	logic valid_s1;

	assign item_stall = valid_s1 && !out_free;
	assign fire       = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.req_type <= req_type;
			item_s1.key_code <= key_code;
		end
	end

endmodule

>>> src/lcps_frame_core.sv
// Effect state registers and the per-word frame update logic.
module lcps_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lcps_pkg::item_t   item_s1,
	output lcps_pkg::result_t result_d
);
	import lcps_pkg::*;

	`include "led_chaser_pattern_sequencer_unit_macros.svh"

	localparam logic [CNT_W:0] LEN_FULL = (CNT_W + 1)'(LED_COUNT);
	localparam logic [CNT_W:0] LEN_HALF = (CNT_W + 1)'(HALF_COUNT);

	mode_t             mode_q, mode_d;
	mode_t             pend_q, pend_d;
	logic              clear_q, clear_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [CNT_W-1:0]  dot_q, dot_d;
	logic [HOLD_W-1:0] hold_q, hold_d;
	pattern_t          pat_q, pat_d;

	logic [CNT_W:0]    fill_inc;
	logic [CNT_W:0]    dot_inc;
	logic [CNT_W:0]    fill_len;
	logic [CNT_W:0]    dot_limit;
	logic [HOLD_W-1:0] hold_inc;
	pattern_t          region;

	assign fill_inc  = {1'b0, fill_q} + 1'b1;
	assign dot_inc   = {1'b0, dot_q} + 1'b1;
	assign dot_limit = LEN_FULL - {1'b0, fill_q};
	assign hold_inc  = hold_q + 1'b1;
	assign fill_len  = (mode_q == MODE_FILL_ENDS || mode_q == MODE_FILL_MID) ? LEN_HALF
		: LEN_FULL;

	always_comb begin
		case (mode_q)
			MODE_FILL_LOW:  region = low_bits({1'b0, fill_q});
			MODE_FILL_HIGH: region = high_bits({1'b0, fill_q});
			MODE_FILL_ENDS: region = low_bits({1'b0, fill_q}) | high_bits({1'b0, fill_q});
			MODE_FILL_MID:  region = mid_bits({1'b0, fill_q});
			MODE_DOT_LOW:   region = low_bits({1'b0, fill_q})
				| bit_at(CNT_W'(LED_COUNT - 1) - dot_q);
			MODE_DOT_HIGH:  region = high_bits({1'b0, fill_q}) | bit_at(dot_q);
			default:        region = clear_q ? '0 : '1;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		pend_d  = pend_q;
		clear_d = clear_q;
		fill_d  = fill_q;
		dot_d   = dot_q;
		hold_d  = hold_q;
		pat_d   = pat_q;
		if (item_s1.req_type == REQ_KEY) begin
			if (item_s1.key_code <= KEY_LAST) begin
				pend_d = mode_t'(item_s1.key_code[2:0]);
				if (mode_q != MODE_BLINK) begin
					mode_d  = mode_t'(item_s1.key_code[2:0]);
					clear_d = 1'b0;
					fill_d  = '0;
					dot_d   = '0;
					hold_d  = '0;
				end
			end
		end else begin
			case (mode_q)
				MODE_FILL_LOW, MODE_FILL_HIGH, MODE_FILL_ENDS, MODE_FILL_MID: begin
					pat_d = clear_q ? ~region : region;
					if (fill_inc >= fill_len) begin
						fill_d  = '0;
						clear_d = !clear_q;
					end else begin
						fill_d = fill_inc[CNT_W-1:0];
					end
				end
				MODE_DOT_LOW, MODE_DOT_HIGH: begin
					pat_d = region;
					if (dot_inc >= dot_limit) begin
						dot_d  = '0;
						fill_d = (fill_inc >= LEN_FULL) ? '0 : fill_inc[CNT_W-1:0];
					end else begin
						dot_d = dot_inc[CNT_W-1:0];
					end
				end
				default: begin
					pat_d = region;
					if (hold_inc >= HOLD_W'(BLINK_HOLD_TICKS)) begin
						hold_d = '0;
						if (clear_q) begin
							mode_d  = pend_q;
							clear_d = 1'b0;
							fill_d  = '0;
							dot_d   = '0;
						end else begin
							clear_d = 1'b1;
						end
					end else begin
						hold_d = hold_inc;
					end
				end
			endcase
		end
	end

	assign result_d.led_pattern  = to_out(pat_d);
	assign result_d.current_mode = mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BLINK;
			pend_q  <= MODE_BLINK;
			clear_q <= 1'b0;
			fill_q  <= '0;
			dot_q   <= '0;
			hold_q  <= '0;
			pat_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			clear_q <= clear_d;
			fill_q  <= fill_d;
			dot_q   <= dot_d;
			hold_q  <= hold_d;
			pat_q   <= pat_d;
		end
	end

	`LCPS_ASSERT_IMP(a_fill_in_range, (mode_q >= MODE_FILL_LOW && mode_q <= MODE_FILL_MID),
		({1'b0, fill_q} < fill_len), "fill count past the effect length")
	`LCPS_ASSERT_IMP(a_dot_in_range, (mode_q == MODE_DOT_LOW || mode_q == MODE_DOT_HIGH),
		({1'b0, dot_q} < dot_limit), "dot position past the stack top")
	`LCPS_ASSERT_IMP(a_hold_in_range, (1'b1), (hold_q < HOLD_W'(BLINK_HOLD_TICKS)),
		"blink hold count past its limit")
	`LCPS_ASSERT_NXT(a_idle_holds, (!fire), ($stable(mode_q) && $stable(pat_q)),
		"effect state moved without a consumed word")

endmodule

>>> src/lcps_out_stage.sv
// Result register: holds the finished word until the consumer takes it.
module lcps_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lcps_pkg::result_t result_d,
	output logic              out_free,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [31:0]       led_pattern,
	output logic [2:0]        current_mode
);
	import lcps_pkg::*;

	logic    out_valid_q;
	result_t result_q;

	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign led_pattern  = result_q.led_pattern;
	assign current_mode = result_q.current_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

endmodule

>>> src/led_chaser_pattern_sequencer_unit.sv
// A word accepted into the input register passes through the frame core into
// the result register and waits on the result port until the consumer takes it.
// Throughput: one word per cycle while the consumer does not stall; the input
// register and the result register let a new word enter while a finished one
// still waits to be taken. Reset (arst_n low, asynchronous): blink effect, all
// LEDs off, all counters cleared, both register stages empty.
module led_chaser_pattern_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        req_type,
	input  logic [3:0]  key_code,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] led_pattern,
	output logic [2:0]  current_mode
);
	import lcps_pkg::*;

	// Handshake between the stages: the core consumes the word held in the
	// input register only when the result register can take its answer.
	logic    out_free;
	logic    fire;
	item_t   item_s1;
	result_t result_d;

	// Input register. It stalls the producer only while it is full and the
	// result register is blocked.
	lcps_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.req_type   (req_type),
		.key_code   (key_code),
		.out_free   (out_free),
		.fire       (fire),
		.item_s1    (item_s1)
	);

	// The effect state lives here. A tick word advances the running effect
	// by one frame; a key word with an effect code selects it at once, or
	// queues it until the blink off phase ends. Other key codes are ignored.
	lcps_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item_s1  (item_s1),
		.result_d (result_d)
	);

	// Result register that faces the consumer.
	lcps_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.result_d     (result_d),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.led_pattern  (led_pattern),
		.current_mode (current_mode)
	);

endmodule

>>> dv/led_chaser_pattern_sequencer_unit_tb.sv
// Self-checking testbench for the LED chaser pattern sequencer unit.
`timescale 1ns / 1ps

module led_chaser_pattern_sequencer_unit_tb;
	import lcps_pkg::*;

	// Codes beyond the effect range are ignored by the block. The first and
	// the last of them are used in the directed rows.
	localparam logic [3:0] KEY_IGNORED_LO = KEY_LAST + 4'd1;
	localparam logic [3:0] KEY_MAX        = 4'hF;

	// A full stacking pass of a dot effect takes 528 frames; the forced
	// dot segments run a little past that so the stack wraps once, even
	// when the first key still waits for a blink off phase to end.
	localparam int DOT_PASS_TICKS  = 536;
	localparam int RANDOM_WORDS    = 1900;
	localparam int QUIET_FROM      = 1700;
	localparam int PRESSURE_CYCLES = 200;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int DIRECTED_ROWS   = 25;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        req_type;
	logic [3:0]  key_code;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] led_pattern;
	logic [2:0]  current_mode;

	led_chaser_pattern_sequencer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.req_type     (req_type),
		.key_code     (key_code),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.led_pattern  (led_pattern),
		.current_mode (current_mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One row of the directed table. When known is set, the frame and mode
	// typed into the row are what the block must return; otherwise the
	// expectation comes from the frame predictor below.
	typedef struct packed {
		logic        req;
		logic [3:0]  key;
		logic        known;
		logic [31:0] pattern;
		logic [2:0]  mode;
	} directed_row_t;

	// The directed walk: the blink phases after reset, ignored codes, a key
	// stored while blinking and applied when the off phase ends, then a
	// short visit to every effect with an abort by key each time, a code
	// that is ignored outside blink, and a return to blink by key.
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{REQ_TICK, 4'd0,                 1'b1, 32'hFFFF_FFFF, MODE_BLINK},
		'{REQ_KEY,  KEY_MAX,              1'b1, 32'hFFFF_FFFF, MODE_BLINK},
		'{REQ_KEY,  4'(MODE_FILL_ENDS),   1'b1, 32'hFFFF_FFFF, MODE_BLINK},
		'{REQ_TICK, KEY_MAX,              1'b1, 32'hFFFF_FFFF, MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b1, 32'h0000_0000, MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b1, 32'h0000_0000, MODE_FILL_ENDS},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  4'(MODE_FILL_LOW),    1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  4'(MODE_FILL_HIGH),   1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  4'(MODE_FILL_MID),    1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  4'(MODE_DOT_LOW),     1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  4'(MODE_DOT_HIGH),    1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  KEY_IGNORED_LO,       1'b0, 32'h0,         MODE_BLINK},
		'{REQ_KEY,  4'(MODE_BLINK),       1'b0, 32'h0,         MODE_BLINK},
		'{REQ_TICK, 4'd0,                 1'b1, 32'hFFFF_FFFF, MODE_BLINK}
	};

	// Frames still owed by the block, oldest first.
	result_t owed_frames [$];
	int      mismatches = 0;

	// Shared control between the stimulus and the receiver.
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;

	// Predictor state: the effect running, the effect queued during blink,
	// the fill or clear half, the frame counters and the frame on show.
	logic [2:0]  chaser_mode;
	logic [2:0]  queued_mode;
	bit          clearing;
	int          fill_cnt;
	int          dot_pos;
	int          hold_cnt;
	logic [31:0] shown;

	function automatic logic [63:0] ones_below(input int k);
		return (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
	endfunction

	// Highest k LEDs of the bank lit.
	function automatic logic [31:0] ones_above(input int k);
		return 32'(~ones_below(LED_COUNT - k));
	endfunction

	function automatic void restart_counters();
		clearing = 1'b0;
		fill_cnt = 0;
		dot_pos  = 0;
		hold_cnt = 0;
	endfunction

	function automatic void reset_chaser();
		chaser_mode = MODE_BLINK;
		queued_mode = MODE_BLINK;
		shown       = '0;
		restart_counters();
	endfunction

	// Advances the predictor by one accepted word and returns the frame and
	// mode that the block must show after it.
	function automatic result_t advance_chaser(input logic req, input logic [3:0] key);
		result_t     res;
		int          len;
		int          cnt;
		int          n;
		logic [31:0] region;
		if (req == REQ_KEY) begin
			// A key never advances the frame. While blinking it is only queued,
			// and the last one before the off phase ends wins.
			if (key <= KEY_LAST) begin
				if (chaser_mode == MODE_BLINK || chaser_mode > MODE_DOT_HIGH) begin
					queued_mode = key[2:0];
				end else begin
					chaser_mode = key[2:0];
					queued_mode = key[2:0];
					restart_counters();
				end
			end
		end else begin
			case (chaser_mode)
				MODE_FILL_LOW, MODE_FILL_HIGH, MODE_FILL_ENDS, MODE_FILL_MID: begin
					len = (chaser_mode >= MODE_FILL_ENDS) ? HALF_COUNT : LED_COUNT;
					cnt = (fill_cnt > len) ? len : fill_cnt;
					case (chaser_mode)
						MODE_FILL_LOW:  region = 32'(ones_below(cnt));
						MODE_FILL_HIGH: region = ones_above(cnt);
						MODE_FILL_ENDS: region = 32'(ones_below(cnt)) | ones_above(cnt);
						default:        region = 32'(ones_below(2 * cnt) << (HALF_COUNT - cnt));
					endcase
					shown = clearing ? ~region : region;
					fill_cnt++;
					if (fill_cnt >= len) begin
						fill_cnt = 0;
						clearing = !clearing;
					end
				end
				MODE_DOT_LOW, MODE_DOT_HIGH: begin
					n = (fill_cnt >= LED_COUNT) ? LED_COUNT - 1 : fill_cnt;
					if (chaser_mode == MODE_DOT_LOW) begin
						shown = 32'(ones_below(n)) |
							(32'd1 << (LED_COUNT - 1 - (dot_pos % LED_COUNT)));
					end else begin
						shown = ones_above(n) | (32'd1 << dot_pos);
					end
					dot_pos++;
					if (dot_pos >= LED_COUNT - n) begin
						dot_pos  = 0;
						fill_cnt = (n + 1 >= LED_COUNT) ? 0 : n + 1;
					end
				end
				default: begin
					// Blink, and the unused code seven that behaves the same.
					shown = clearing ? '0 : 32'(ones_below(LED_COUNT));
					hold_cnt++;
					if (hold_cnt >= BLINK_HOLD_TICKS) begin
						hold_cnt = 0;
						if (clearing) begin
							chaser_mode = queued_mode;
							restart_counters();
						end else begin
							clearing = 1'b1;
						end
					end
				end
			endcase
		end
		res.led_pattern  = shown;
		res.current_mode = chaser_mode;
		return res;
	endfunction

	// Offers one word and holds it until the block takes it, then records
	// what the block owes for it. The typed frame, where given, replaces the
	// predicted one, but the predictor advances either way. After the word
	// the sender may go idle for a short burst.
	task automatic send_word(input logic req, input logic [3:0] key, input logic known,
	                         input result_t typed);
		result_t predicted;
		item_valid <= 1'b1;
		req_type   <= req;
		key_code   <= key;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		predicted = advance_chaser(req, key);
		owed_frames.push_back(known ? typed : predicted);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Receiver: calm stretches alternate with stall bursts of random length.
	// Once, on request, it holds off long enough for the block to fill up
	// and stall its input while the sender keeps offering words.
	initial begin
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
				@(posedge clk);
			end else if (quiet || $urandom_range(0, 2) == 0) begin
				result_stall <= 1'b0;
				repeat ($urandom_range(5, 30)) @(posedge clk);
			end else begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Every taken result word is checked field by field against the oldest
	// frame still owed.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (owed_frames.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing owed: pattern %h mode %0d",
					$time, led_pattern, current_mode);
			end else begin
				want = owed_frames.pop_front();
				if (led_pattern !== want.led_pattern) begin
					mismatches++;
					$display("%0t: led_pattern expected %h, got %h",
						$time, want.led_pattern, led_pattern);
				end
				if (current_mode !== want.current_mode) begin
					mismatches++;
					$display("%0t: current_mode expected %0d, got %0d",
						$time, want.current_mode, current_mode);
				end
			end
		end
	end

	// The watchdog ends a run in which no word moves on either side for
	// far longer than the longest correct hold-off.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int          seg;
		int          len;
		int          sent;
		logic [3:0]  code;
		result_t     typed;
		item_valid = 1'b0;
		req_type   = REQ_TICK;
		key_code   = '0;
		arst_n     = 1'b0;
		reset_chaser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			typed.led_pattern  = DIRECTED[r].pattern;
			typed.current_mode = DIRECTED[r].mode;
			send_word(DIRECTED[r].req, DIRECTED[r].key, DIRECTED[r].known, typed);
		end

		// Random part. The first two segments run each dot effect through a
		// whole stacking pass; after that every segment picks a key (mostly
		// a valid effect) and a run of ticks, a few of them long enough to
		// wrap the fill effects. Stray ignored keys are mixed in as noise on
		// top of the ticks. Zero-length runs give back-to-back keys, which
		// exercises the queued key while blinking. The long receiver hold
		// comes first.
		hold_req = 1'b1;
		sent     = 0;
		seg      = 0;
		while (sent < RANDOM_WORDS) begin
			if (seg < 2) begin
				code = (seg == 0) ? 4'(MODE_DOT_LOW) : 4'(MODE_DOT_HIGH);
				len  = DOT_PASS_TICKS;
			end else begin
				code = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, KEY_LAST))
				                                 : 4'($urandom_range(KEY_LAST + 1, KEY_MAX));
				len  = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 300)
				                                   : $urandom_range(0, 40);
			end
			send_word(REQ_KEY, code, 1'b0, typed);
			sent++;
			for (int t = 0; t < len && sent < RANDOM_WORDS; t++) begin
				if ($urandom_range(0, 24) == 0) begin
					send_word(REQ_KEY, 4'($urandom_range(KEY_LAST + 1, KEY_MAX)), 1'b0, typed);
					sent++;
				end
				send_word(REQ_TICK, 4'($urandom_range(0, KEY_MAX)), 1'b0, typed);
				sent++;
				// The tail of the run goes without idling on either side.
				quiet = (sent > QUIET_FROM);
			end
			seg++;
		end
		item_valid <= 1'b0;

		while (owed_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_frames.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/lcps_pkg.sv
src/lcps_in_stage.sv
src/lcps_frame_core.sv
src/lcps_out_stage.sv
src/led_chaser_pattern_sequencer_unit.sv
dv/led_chaser_pattern_sequencer_unit_tb.sv
